// ===== hw/rtl/quad_motor_tilt_mixer_top_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the tilt mixer
// Shared concurrent-check wrappers on clk_i / rst_ni.
// ----------------------------------------------------------------------------
`ifndef QUAD_MOTOR_TILT_MIXER_TOP_MACROS_SVH
`define QUAD_MOTOR_TILT_MIXER_TOP_MACROS_SVH

// same-cycle implication
`define QMTM_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define QMTM_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/qmtm_pkg.sv =====
// ----------------------------------------------------------------------------
// qmtm_pkg
// Types, register indexes and mixing arithmetic for the tilt mixer.
// ----------------------------------------------------------------------------
package qmtm_pkg;

  localparam int unsigned DriveW   = 16;
  localparam int unsigned MagW     = 17;  // |-32768| needs 17 bits
  localparam int unsigned GainW    = 8;
  localparam int unsigned BattW    = 12;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned ProdW    = MagW + GainW;

  // floor(x/10) = (x * ceil(2^27/10)) >> 27, exact for x < 2^26
  localparam int unsigned DivTenMulW  = 24;
  localparam int unsigned DivTenShift = 27;
  localparam logic [DivTenMulW-1:0] DivTenMul = 24'd13421773;
  localparam int unsigned QuotW = ProdW + DivTenMulW - DivTenShift;

  localparam logic [3:0] MinusRound = 4'd9;  // turns floor into ceil

  localparam logic [DriveW-1:0] BaseSpeedRst  = 16'd10000;
  localparam logic [DriveW-1:0] RampStepRst   = 16'd100;
  localparam logic [BattW-1:0]  BattThreshRst = 12'd256;
  localparam logic [GainW-1:0]  PlusGainRst   = 8'd66;
  localparam logic [GainW-1:0]  MinusGainRst  = 8'd5;

  typedef enum logic [1:0] {
    MODE_RAMP = 2'd0,
    MODE_FLY  = 2'd1,
    MODE_LOW  = 2'd2
  } mode_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_BASE_SPEED  = 3'd0,
    CFG_RAMP_STEP   = 3'd1,
    CFG_BATT_THRESH = 3'd2,
    CFG_PLUS_GAIN   = 3'd3,
    CFG_MINUS_GAIN  = 3'd4
  } cfg_idx_e;

  typedef enum logic [1:0] {
    ACT_HOLD = 2'd0,
    ACT_RAMP = 2'd1,
    ACT_FLY  = 2'd2
  } act_e;

  function automatic logic [MagW-1:0] tilt_mag(input logic signed [DriveW-1:0] a);
    logic signed [MagW-1:0] ext;
    ext = {a[DriveW-1], a};
    return a[DriveW-1] ? MagW'(-ext) : MagW'(ext);
  endfunction

  function automatic logic [QuotW-1:0] div_ten(input logic [ProdW-1:0] x);
    logic [ProdW+DivTenMulW-1:0] p;
    p = {{DivTenMulW{1'b0}}, x} * {{ProdW{1'b0}}, DivTenMul};
    return p[DivTenShift +: QuotW];
  endfunction

  // base + floor(prod/10), saturated high
  function automatic logic [DriveW-1:0] side_plus(input logic [DriveW-1:0] base,
                                                  input logic [ProdW-1:0]  prod);
    logic [QuotW:0] s;
    s = {{(QuotW+1-DriveW){1'b0}}, base} + {1'b0, div_ten(prod)};
    return (|s[QuotW:DriveW]) ? {DriveW{1'b1}} : s[DriveW-1:0];
  endfunction

  // base - ceil(prod/10), saturated at zero; prod already carries the +9
  function automatic logic [DriveW-1:0] side_minus(input logic [DriveW-1:0] base,
                                                   input logic [ProdW-1:0]  prod);
    logic [QuotW-1:0] d;
    d = div_ten(prod);
    return (d >= {{(QuotW-DriveW){1'b0}}, base}) ? '0 : base - d[DriveW-1:0];
  endfunction

endpackage

// ===== hw/rtl/quad_motor_tilt_mixer_top.sv =====
// ----------------------------------------------------------------------------
// quad_motor_tilt_mixer_top
// Four-motor drive mixer with ramp / fly / battery-low sequencer.
// ----------------------------------------------------------------------------
//
//  channel | handshake                  | beat payload
//  --------+----------------------------+-------------------------------------
//  in      | in_valid_i / in_stall_o    | opcode, accel_x, accel_y, battery
//  out     | out_valid_o / out_stall_i  | motor_one..four, drives_updated, mode
//  cfg     | cfg_we_i (no handshake)    | cfg_idx_i, cfg_wdata_i
//
//  One beat per cycle sustained while out_stall_i stays low. The decode
//  register loads at the input accept edge, then the gain multiply stage,
//  then the divide-by-ten/saturate stage that loads drives and out_valid_o.
//  Mode and ramp update at the accept edge, so back-to-back beats see them.
//  Reset: ramp mode, ramp 0, drives 0, config at defaults, pipeline empty.
//  A stalled output holds; stages behind it keep filling until full.
// ----------------------------------------------------------------------------
`include "quad_motor_tilt_mixer_top_macros.svh"

module quad_motor_tilt_mixer_top (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // configuration
  input  logic                                cfg_we_i,
  input  logic [qmtm_pkg::CfgIdxW-1:0]        cfg_idx_i,
  input  logic [qmtm_pkg::DriveW-1:0]         cfg_wdata_i,
  // input beats
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic                                opcode_i,
  input  logic signed [qmtm_pkg::DriveW-1:0]  accel_x_i,
  input  logic signed [qmtm_pkg::DriveW-1:0]  accel_y_i,
  input  logic [qmtm_pkg::BattW-1:0]          battery_level_i,
  // result beats
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic [qmtm_pkg::DriveW-1:0]         motor_one_o,
  output logic [qmtm_pkg::DriveW-1:0]         motor_two_o,
  output logic [qmtm_pkg::DriveW-1:0]         motor_three_o,
  output logic [qmtm_pkg::DriveW-1:0]         motor_four_o,
  output logic                                drives_updated_o,
  output logic [1:0]                          mode_now_o
);
  import qmtm_pkg::*;

  // -------------------------------------------------------------------------
  // Configuration registers
  // -------------------------------------------------------------------------
  logic [DriveW-1:0] base_q, step_q;
  logic [BattW-1:0]  thresh_q;
  logic [GainW-1:0]  plus_gain_q, minus_gain_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q       <= BaseSpeedRst;
      step_q       <= RampStepRst;
      thresh_q     <= BattThreshRst;
      plus_gain_q  <= PlusGainRst;
      minus_gain_q <= MinusGainRst;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_BASE_SPEED:  base_q       <= cfg_wdata_i;
        CFG_RAMP_STEP:   step_q       <= cfg_wdata_i;
        CFG_BATT_THRESH: thresh_q     <= cfg_wdata_i[BattW-1:0];
        CFG_PLUS_GAIN:   plus_gain_q  <= cfg_wdata_i[GainW-1:0];
        CFG_MINUS_GAIN:  minus_gain_q <= cfg_wdata_i[GainW-1:0];
        default: ;  // unmapped index, ignored
      endcase
    end
  end

  // -------------------------------------------------------------------------
  // Pipeline flow control: s1 (decode) -> s2 (multiply) -> out (drives)
  // -------------------------------------------------------------------------
  logic s1_vld_q, s2_vld_q, out_vld_q;
  logic out_adv, s2_free, s1_free, s1_adv, s2_adv, in_acc;

  assign out_adv    = !out_vld_q || !out_stall_i;
  assign s2_free    = !s2_vld_q || out_adv;
  assign s2_adv     = s2_vld_q && out_adv;
  assign s1_free    = !s1_vld_q || s2_free;
  assign s1_adv     = s1_vld_q && s2_free;
  assign in_acc     = in_valid_i && s1_free;
  assign in_stall_o = !s1_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q  <= 1'b0;
      s2_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (s1_free) s1_vld_q  <= in_valid_i;
      if (s2_free) s2_vld_q  <= s1_vld_q;
      if (out_adv) out_vld_q <= s2_vld_q;
    end
  end

  // -------------------------------------------------------------------------
  // Sequencer: mode and ramp advance at the accept edge
  // -------------------------------------------------------------------------
  mode_e             mode_q, mode_d;
  logic [DriveW-1:0] ramp_q, ramp_d;
  act_e              act_d;
  logic [DriveW:0]   ramp_sum;

  assign ramp_sum = {1'b0, ramp_q} + {1'b0, step_q};

  always_comb begin
    mode_d = mode_q;
    ramp_d = ramp_q;
    act_d  = ACT_HOLD;
    priority if (opcode_i) begin
      // battery sample: equal level leaves mode alone
      priority if (battery_level_i < thresh_q) begin
        mode_d = MODE_LOW;
      end else if (mode_q == MODE_LOW && battery_level_i > thresh_q) begin
        mode_d = MODE_RAMP;
      end else begin
        // equal level, or high level outside low mode: no change
      end
    end else if (mode_q == MODE_RAMP) begin
      act_d  = ACT_RAMP;
      ramp_d = ramp_sum[DriveW] ? {DriveW{1'b1}} : ramp_sum[DriveW-1:0];
      if (ramp_d >= base_q) mode_d = MODE_FLY;
    end else if (mode_q == MODE_FLY) begin
      act_d = ACT_FLY;
    end else begin
      // tick in battery-low mode: drives held
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MODE_RAMP;
      ramp_q <= '0;
    end else if (in_acc) begin
      mode_q <= mode_d;
      ramp_q <= ramp_d;
    end
  end

  // -------------------------------------------------------------------------
  // Stage 1: decoded action, old ramp value, tilt magnitude and side
  // -------------------------------------------------------------------------
  act_e              s1_act_q;
  mode_e             s1_mode_q;
  logic [DriveW-1:0] s1_ramp_q;
  logic [MagW-1:0]   s1_mag_x_q, s1_mag_y_q;
  logic              s1_pos_x_q, s1_pos_y_q;

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_act_q   <= act_d;
      s1_mode_q  <= mode_d;
      s1_ramp_q  <= ramp_q;
      s1_mag_x_q <= tilt_mag(accel_x_i);
      s1_mag_y_q <= tilt_mag(accel_y_i);
      // zero tilt counts as the non-positive side
      s1_pos_x_q <= !accel_x_i[DriveW-1] && (|accel_x_i);
      s1_pos_y_q <= !accel_y_i[DriveW-1] && (|accel_y_i);
    end
  end

  // -------------------------------------------------------------------------
  // Stage 2: magnitude times gain (minus side pre-rounded for ceil)
  // -------------------------------------------------------------------------
  act_e              s2_act_q;
  mode_e             s2_mode_q;
  logic [DriveW-1:0] s2_ramp_q;
  logic              s2_pos_x_q, s2_pos_y_q;
  logic [ProdW-1:0]  s2_px_q, s2_mx_q, s2_py_q, s2_my_q;
  logic [ProdW-1:0]  px_d, mx_d, py_d, my_d;

  assign px_d = {{GainW{1'b0}}, s1_mag_x_q} * {{MagW{1'b0}}, plus_gain_q};
  assign py_d = {{GainW{1'b0}}, s1_mag_y_q} * {{MagW{1'b0}}, plus_gain_q};
  assign mx_d = ({{GainW{1'b0}}, s1_mag_x_q} * {{MagW{1'b0}}, minus_gain_q})
                + ProdW'(MinusRound);
  assign my_d = ({{GainW{1'b0}}, s1_mag_y_q} * {{MagW{1'b0}}, minus_gain_q})
                + ProdW'(MinusRound);

  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      s2_act_q   <= s1_act_q;
      s2_mode_q  <= s1_mode_q;
      s2_ramp_q  <= s1_ramp_q;
      s2_pos_x_q <= s1_pos_x_q;
      s2_pos_y_q <= s1_pos_y_q;
      s2_px_q    <= px_d;
      s2_mx_q    <= mx_d;
      s2_py_q    <= py_d;
      s2_my_q    <= my_d;
    end
  end

  // -------------------------------------------------------------------------
  // Stage 3: /10, base offset, saturation; drive registers double as the
  // output register (held drives come straight from here)
  // -------------------------------------------------------------------------
  logic [DriveW-1:0] drv_q [4];
  logic [DriveW-1:0] drv_d [4];
  logic [DriveW-1:0] plus_x, minus_x, plus_y, minus_y;
  logic              upd_q;
  mode_e             mode_out_q;

  assign plus_x  = side_plus(base_q, s2_px_q);
  assign minus_x = side_minus(base_q, s2_mx_q);
  assign plus_y  = side_plus(base_q, s2_py_q);
  assign minus_y = side_minus(base_q, s2_my_q);

  always_comb begin
    for (int k = 0; k < 4; k++) drv_d[k] = drv_q[k];
    unique case (s2_act_q)
      ACT_RAMP: begin
        for (int k = 0; k < 4; k++) drv_d[k] = s2_ramp_q;
      end
      ACT_FLY: begin
        // x axis: motors one and three; y axis: motors two and four
        drv_d[0] = s2_pos_x_q ? minus_x : plus_x;
        drv_d[2] = s2_pos_x_q ? plus_x  : minus_x;
        drv_d[1] = s2_pos_y_q ? minus_y : plus_y;
        drv_d[3] = s2_pos_y_q ? plus_y  : minus_y;
      end
      default: ;  // hold
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < 4; k++) drv_q[k] <= '0;
      upd_q      <= 1'b0;
      mode_out_q <= MODE_RAMP;
    end else if (s2_adv) begin
      for (int k = 0; k < 4; k++) drv_q[k] <= drv_d[k];
      upd_q      <= (s2_act_q != ACT_HOLD);
      mode_out_q <= s2_mode_q;
    end
  end

  assign out_valid_o      = out_vld_q;
  assign motor_one_o      = drv_q[0];
  assign motor_two_o      = drv_q[1];
  assign motor_three_o    = drv_q[2];
  assign motor_four_o     = drv_q[3];
  assign drives_updated_o = upd_q;
  assign mode_now_o       = mode_out_q;

  // -------------------------------------------------------------------------
  // Checks
  // -------------------------------------------------------------------------
  `QMTM_ASSERT_NEXT(a_ramp_monotonic, 1'b1,
                    ramp_q >= $past(ramp_q), "ramp value decreased")
  `QMTM_ASSERT_IMPL(a_low_no_update, out_vld_q && upd_q,
                    mode_out_q != MODE_LOW, "drives updated in low mode")
  `QMTM_ASSERT_NEXT(a_hold_keeps_drives, s2_adv && s2_act_q == ACT_HOLD,
                    drv_q[0] == $past(drv_q[0]) && drv_q[3] == $past(drv_q[3]),
                    "held drives changed")
  `QMTM_ASSERT_IMPL(a_stall_only_when_full, in_stall_o,
                    s1_vld_q && s2_vld_q && out_vld_q, "input stalled with room in pipeline")

endmodule

// ===== test/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the four-motor tilt mixer. A queue of samples feeds
// a handshake driver; every accepted beat advances a local model of the mode
// sequencer, ramp and drive mixing, and the monitor compares each result beat
// with the oldest predicted drive set while both sides idle at random.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import qmtm_pkg::*;

  // opcode field values
  localparam logic OP_TICK = 1'b0;
  localparam logic OP_BATT = 1'b1;

  localparam int unsigned DRIVE_TOP = 65535;

  // one input beat
  typedef struct packed {
    logic               opcode;
    logic signed [15:0] ax;
    logic signed [15:0] ay;
    logic [11:0]        level;
  } mixer_in_t;

  // one result beat; motor[0] is motor one
  typedef struct packed {
    logic [3:0][15:0] motor;
    logic             updated;
    logic [1:0]       mode;
  } drive_set_t;

  // --------------------------------------------------------------------------
  // Clock, reset and DUT hookup. All inputs start at known values.
  // --------------------------------------------------------------------------
  logic               clk_i           = 1'b0;
  logic               rst_ni          = 1'b0;
  logic               cfg_we_i        = 1'b0;
  logic [CfgIdxW-1:0] cfg_idx_i       = CFG_BASE_SPEED;
  logic [DriveW-1:0]  cfg_wdata_i     = '0;
  logic               in_valid_i      = 1'b0;
  logic               in_stall_o;
  logic               opcode_i        = OP_TICK;
  logic signed [15:0] accel_x_i       = '0;
  logic signed [15:0] accel_y_i       = '0;
  logic [BattW-1:0]   battery_level_i = '0;
  logic               out_valid_o;
  logic               out_stall_i     = 1'b0;
  logic [DriveW-1:0]  motor_one_o;
  logic [DriveW-1:0]  motor_two_o;
  logic [DriveW-1:0]  motor_three_o;
  logic [DriveW-1:0]  motor_four_o;
  logic               drives_updated_o;
  logic [1:0]         mode_now_o;

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  // single reset pulse, released on a rising edge
  initial begin
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  quad_motor_tilt_mixer_top DUT (.*);

  // --------------------------------------------------------------------------
  // Local model: configuration copy and sequencer state.
  // --------------------------------------------------------------------------
  logic [15:0]      hover_speed = BaseSpeedRst;
  logic [15:0]      ramp_inc    = RampStepRst;
  logic [11:0]      trip_level  = BattThreshRst;
  logic [7:0]       gain_up     = PlusGainRst;
  logic [7:0]       gain_down   = MinusGainRst;
  mode_e            mixer_mode  = MODE_RAMP;
  logic [15:0]      ramp_level  = '0;
  logic [3:0][15:0] drive       = '0;

  // run statistics
  int unsigned n_accepted = 0;
  int unsigned n_ramp     = 0;
  int unsigned n_fly      = 0;
  int unsigned n_held     = 0;
  int unsigned n_batt     = 0;
  int unsigned n_settings = 0;
  int unsigned n_checked  = 0;
  int unsigned mismatches = 0;

  mixer_in_t  pending_samples[$];
  drive_set_t expected_drives[$];

  // base + floor(|t| * up / 10), clipped at full scale
  function automatic logic [15:0] tilted_side_drive(input logic [16:0] mag);
    int unsigned s;
    s = hover_speed + (mag * gain_up) / 10;
    return (s > DRIVE_TOP) ? 16'hFFFF : 16'(s);
  endfunction

  // base - ceil(|t| * down / 10), clipped at zero
  function automatic logic [15:0] opposite_side_drive(input logic [16:0] mag);
    int unsigned d;
    d = (mag * gain_down + 9) / 10;
    return (d >= hover_speed) ? 16'd0 : 16'(hover_speed - d);
  endfunction

  // one tilt axis: near motor takes the non-positive side, far the positive
  function automatic void mix_axis(input logic [15:0] raw, input int near_m,
                                   input int far_m);
    logic [16:0] mag;
    logic        pos;
    mag = raw[15] ? (17'h10000 - {1'b0, raw}) : {1'b0, raw};
    pos = !raw[15] && (raw != 16'd0);
    if (pos) begin
      drive[far_m]  = tilted_side_drive(mag);
      drive[near_m] = opposite_side_drive(mag);
    end else begin
      drive[near_m] = tilted_side_drive(mag);
      drive[far_m]  = opposite_side_drive(mag);
    end
  endfunction

  // advance the sequencer by one accepted beat, return the drive set it shows
  function automatic drive_set_t advance_mixer(input mixer_in_t it);
    drive_set_t  res;
    int unsigned sum;
    res.updated = 1'b0;
    if (it.opcode == OP_BATT) begin
      n_batt++;
      if (it.level < trip_level) begin
        mixer_mode = MODE_LOW;
      end else if (mixer_mode == MODE_LOW && it.level > trip_level) begin
        mixer_mode = MODE_RAMP;
      end
    end else if (mixer_mode == MODE_RAMP) begin
      n_ramp++;
      for (int k = 0; k < 4; k++) drive[k] = ramp_level;
      sum = ramp_level + ramp_inc;
      ramp_level = (sum > DRIVE_TOP) ? 16'hFFFF : 16'(sum);
      if (ramp_level >= hover_speed) mixer_mode = MODE_FLY;
      res.updated = 1'b1;
    end else if (mixer_mode == MODE_FLY) begin
      n_fly++;
      mix_axis(it.ax, 0, 2);
      mix_axis(it.ay, 1, 3);
      res.updated = 1'b1;
    end else begin
      n_held++;
    end
    res.motor = drive;
    res.mode  = mixer_mode;
    return res;
  endfunction

  // --------------------------------------------------------------------------
  // Idle lengths: mostly none or short, now and then long.
  // --------------------------------------------------------------------------
  function automatic int unsigned idle_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // --------------------------------------------------------------------------
  // Driver: pops samples, holds the beat until accepted, predicts on accept.
  // --------------------------------------------------------------------------
  mixer_in_t   cur_sample;
  int unsigned tx_gap  = 0;
  int unsigned tx_calm = 0;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      tx_gap = 0;
    end else begin
      if (in_valid_i && !in_stall_o) begin
        expected_drives.push_back(advance_mixer(cur_sample));
        n_accepted++;
      end
      // a stalled beat stays put; otherwise idle out the gap or launch the next
      if (!in_valid_i || !in_stall_o) begin
        if (tx_gap > 0) begin
          tx_gap--;
          in_valid_i <= 1'b0;
        end else if (pending_samples.size() > 0) begin
          cur_sample = pending_samples.pop_front();
          opcode_i        <= cur_sample.opcode;
          accel_x_i       <= cur_sample.ax;
          accel_y_i       <= cur_sample.ay;
          battery_level_i <= cur_sample.level;
          in_valid_i      <= 1'b1;
          // gap after this beat; calm stretches send back to back
          if (tx_calm > 0) begin
            tx_calm--;
            tx_gap = 0;
          end else if ($urandom_range(0, 39) == 0) begin
            tx_calm = $urandom_range(20, 80);
            tx_gap  = 0;
          end else begin
            tx_gap = idle_len();
          end
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Monitor: checks each accepted result beat and drives out_stall_i.
  // --------------------------------------------------------------------------
  logic        rx_hold = 1'b0;
  int unsigned rx_wait = 0;
  int unsigned rx_calm = 0;
  drive_set_t  seen_set;
  drive_set_t  want_set;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        seen_set.motor   = {motor_four_o, motor_three_o, motor_two_o, motor_one_o};
        seen_set.updated = drives_updated_o;
        seen_set.mode    = mode_now_o;
        n_checked++;
        if (expected_drives.size() == 0) begin
          if (mismatches < 10)
            $display("[%0t] result beat with nothing expected: m=%0d/%0d/%0d/%0d upd=%0b mode=%0d",
                     $time, seen_set.motor[0], seen_set.motor[1], seen_set.motor[2],
                     seen_set.motor[3], seen_set.updated, seen_set.mode);
          mismatches++;
        end else begin
          want_set = expected_drives.pop_front();
          if (seen_set.motor !== want_set.motor || seen_set.updated !== want_set.updated ||
              seen_set.mode !== want_set.mode) begin
            if (mismatches < 10) begin
              $display("[%0t] drive mismatch on result %0d", $time, n_checked);
              $display("  want m=%0d/%0d/%0d/%0d upd=%0b mode=%0d",
                       want_set.motor[0], want_set.motor[1], want_set.motor[2],
                       want_set.motor[3], want_set.updated, want_set.mode);
              $display("  got  m=%0d/%0d/%0d/%0d upd=%0b mode=%0d",
                       seen_set.motor[0], seen_set.motor[1], seen_set.motor[2],
                       seen_set.motor[3], seen_set.updated, seen_set.mode);
            end
            mismatches++;
          end
        end
      end
      // stall pattern for the next cycle
      if (rx_hold) begin
        out_stall_i <= 1'b1;
      end else if (rx_wait > 0) begin
        rx_wait--;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= 1'b0;
        if (rx_calm > 0) rx_calm--;
        else if ($urandom_range(0, 49) == 0) rx_calm = $urandom_range(20, 80);
        else rx_wait = idle_len();
      end
    end
  end

  // long receiver hold-off mid run: the pipe fills and in_stall_o must rise
  initial begin
    wait (n_accepted >= 500);
    @(posedge clk_i);
    rx_hold <= 1'b1;
    repeat (300) @(posedge clk_i);
    rx_hold <= 1'b0;
  end

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------
  function automatic void queue_tick(input logic signed [15:0] x, input logic signed [15:0] y);
    mixer_in_t s;
    s.opcode = OP_TICK;
    s.ax     = x;
    s.ay     = y;
    s.level  = 12'($urandom);
    pending_samples.push_back(s);
  endfunction

  function automatic void queue_battery(input logic [11:0] lvl);
    mixer_in_t s;
    s.opcode = OP_BATT;
    s.ax     = 16'($urandom);
    s.ay     = 16'($urandom);
    s.level  = lvl;
    pending_samples.push_back(s);
  endfunction

  // tilt with extra weight on the corners
  function automatic logic [15:0] pick_tilt();
    if ($urandom_range(0, 99) >= 15) return 16'($urandom);
    case ($urandom_range(0, 4))
      0:       return 16'h8000;
      1:       return 16'h7FFF;
      2:       return 16'h0000;
      3:       return 16'h0001;
      default: return 16'hFFFF;
    endcase
  endfunction

  // battery level around the current threshold
  function automatic logic [11:0] pick_level();
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r < 4) return (trip_level == 12'hFFF) ? trip_level
                                              : 12'($urandom_range(trip_level + 1, 4095));
    if (r < 6) return (trip_level == 12'h000) ? trip_level
                                              : 12'($urandom_range(0, trip_level - 1));
    if (r < 7) return trip_level;
    return 12'($urandom);
  endfunction

  function automatic void queue_random();
    if ($urandom_range(0, 99) < 78) queue_tick(pick_tilt(), pick_tilt());
    else queue_battery(pick_level());
  endfunction

  task automatic write_reg(input cfg_idx_e idx, input logic [15:0] val);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= val;
  endtask

  // program all five registers while idle and mirror them into the model
  task automatic program_mixer(input logic [15:0] base, input logic [15:0] step,
                               input logic [11:0] thr, input logic [7:0] up,
                               input logic [7:0] down);
    write_reg(CFG_BASE_SPEED, base);
    write_reg(CFG_RAMP_STEP, step);
    write_reg(CFG_BATT_THRESH, 16'(thr));
    write_reg(CFG_PLUS_GAIN, 16'(up));
    write_reg(CFG_MINUS_GAIN, 16'(down));
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    hover_speed = base;
    ramp_inc    = step;
    trip_level  = thr;
    gain_up     = up;
    gain_down   = down;
    n_settings++;
    @(negedge clk_i);
  endtask

  // wait until everything is sent and answered, then let the 3-stage pipe settle
  task automatic wait_drained();
    do @(negedge clk_i);
    while (pending_samples.size() != 0 || in_valid_i || expected_drives.size() != 0);
    repeat (4) @(negedge clk_i);
  endtask

  // --------------------------------------------------------------------------
  // Test sequence
  // --------------------------------------------------------------------------
  initial begin
    wait (rst_ni);
    repeat (2) @(posedge clk_i);

    // short ramp: three ticks reach fly
    program_mixer(16'd300, 16'd100, 12'd256, 8'd66, 8'd5);
    queue_tick(16'sh0000, 16'sh0000);
    queue_tick(16'sh7FFF, 16'sh8000);        // tilt ignored while ramping
    queue_tick(16'shFFFF, 16'sh0001);        // ramp hits base
    queue_tick(16'sh8000, 16'sh7FFF);        // full tilt, both sides clip
    queue_tick(16'sh0000, 16'sh0000);        // zero tilt on the non-positive side
    queue_tick(16'sh0001, 16'shFFFF);
    queue_tick(16'sh7FFF, 16'sh7FFF);
    queue_battery(12'd256);                  // at threshold: no change
    queue_battery(12'd255);                  // below: battery low
    queue_tick(16'sh0064, 16'sh0064);        // drives held
    queue_battery(12'd256);                  // at threshold while low: stays low
    queue_battery(12'hFFF);                  // above: back to ramp
    queue_tick(16'sh0005, 16'sh0005);        // ramp kept, flies at once
    queue_battery(12'd0);
    queue_battery(12'd257);
    wait_drained();

    // zero base speed, full gains, zero threshold
    program_mixer(16'd0, 16'd0, 12'd0, 8'd255, 8'd255);
    queue_tick(16'sh8000, 16'sh7FFF);        // first ramp tick goes to fly
    queue_tick(16'sh8000, 16'sh8000);
    queue_tick(16'sh7FFF, 16'sh0000);
    queue_battery(12'd0);                    // equal to a zero threshold

    // random phases, one register setting each
    for (int p = 0; p < 6; p++) begin
      wait_drained();
      case (p)
        0:       program_mixer(BaseSpeedRst, RampStepRst, BattThreshRst, PlusGainRst,
                               MinusGainRst);
        1:       program_mixer(16'd0, 16'd0, 12'd0, 8'd255, 8'd255);
        3:       program_mixer(16'hFFFF, 16'($urandom_range(1, 50)), 12'hFFF, 8'd0, 8'd0);
        default: program_mixer(16'($urandom), 16'($urandom_range(0, 1500)), 12'($urandom),
                               8'($urandom), 8'($urandom));
      endcase
      repeat (205) queue_random();
    end

    // ramp saturation last: the ramp never rewinds, so it stays pinned after
    wait_drained();
    program_mixer(16'hFFFF, 16'hFFFF, 12'd4000, 8'd0, 8'd0);
    queue_battery(12'd0);
    queue_battery(12'hFFF);
    queue_tick(16'sh1234, 16'sh4321);        // ramp + step clips at full scale
    queue_tick(16'sh7FFF, 16'sh8000);
    queue_battery(12'd4001);

    wait_drained();
    repeat (10) @(posedge clk_i);
    $display("Sent %0d beats over %0d register settings: %0d ramp, %0d fly, %0d held ticks",
             n_accepted, n_settings, n_ramp, n_fly, n_held);
    $display("plus %0d battery samples; %0d result beats checked, %0d mismatches",
             n_batt, n_checked, mismatches);
    if (mismatches == 0 && expected_drives.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  // watchdog
  initial begin
    #10ms;
    $display("Timeout with %0d results outstanding", expected_drives.size());
    $display("Regression FAIL");
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+hw/rtl
hw/rtl/qmtm_pkg.sv
hw/rtl/quad_motor_tilt_mixer_top.sv
test/tb_top.sv
